### hw/rtl/fen_syntax_checker_unit_macros.svh
// ----------------------------------------------------------------------------
// FEN syntax checker assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FEN_SYNTAX_CHECKER_UNIT_MACROS_SVH
`define FEN_SYNTAX_CHECKER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define FSC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fsc check failed");
// Next-cycle implication, checked outside reset.
`define FSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fsc check failed");
`else
`define FSC_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define FSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### hw/rtl/fsc_pkg.sv
// ----------------------------------------------------------------------------
// FEN syntax checker package
// Shared byte classification, queue status and token codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fsc_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // Token positions within a position string
    localparam logic [2:0] TOK_PLACE  = 3'd0;
    localparam logic [2:0] TOK_SIDE   = 3'd1;
    localparam logic [2:0] TOK_CASTLE = 3'd2;
    localparam logic [2:0] TOK_EP     = 3'd3;
    localparam logic [2:0] TOK_HALF   = 3'd4;
    localparam logic [2:0] TOK_FULL   = 3'd5;
    localparam logic [2:0] TOK_DONE   = 3'd6;
    localparam logic [2:0] TOK_MAX    = 3'd7;

    // One classified word: the flags overlap ('b' is a piece, a side and a file)
    typedef struct packed {
        logic       last;
        logic       blank;
        logic       slash;
        logic       dash;
        logic       piece;
        logic       digit;
        logic [3:0] dval;
        logic       side;
        logic       castle;
        logic       file;
        logic       ep_rank;
    } fsc_cls_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fsc_qstat_t;

    function automatic fsc_cls_t classify(input logic [7:0] c, input logic last);
        fsc_cls_t   r;
        logic [7:0] diff;
        diff      = c - 8'h30;
        r.last    = last;
        r.blank   = (c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D});
        r.slash   = (c == "/");
        r.dash    = (c == "-");
        r.piece   = (c inside {"p", "r", "n", "b", "q", "k", "P", "R", "N", "B", "Q", "K"});
        r.digit   = (c inside {["0":"9"]});
        r.dval    = diff[3:0];
        r.side    = (c == "w") || (c == "b");
        r.castle  = (c inside {"K", "Q", "k", "q"});
        r.file    = (c inside {["a":"h"]});
        r.ep_rank = (c == "3") || (c == "6");
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/fsc_front.sv
// ----------------------------------------------------------------------------
// FEN syntax checker front end
// Accept a word, classify the byte and hold it until the queue takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsc_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        in_char,
    input  wire logic              in_last,
    input  wire fsc_pkg::fsc_qstat_t q_stat,
    output logic                   push,
    output fsc_pkg::fsc_cls_t      push_data
);

    logic              hold_valid_reg;
    logic              hold_valid_next;
    fsc_pkg::fsc_cls_t hold_data_reg;

    assign push      = hold_valid_reg && !q_stat.full;
    assign in_ready  = !hold_valid_reg || !q_stat.full;
    assign push_data = hold_data_reg;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (in_valid && in_ready) begin
            hold_valid_next = 1'b1;
        end else if (push) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            hold_data_reg <= fsc_pkg::classify(in_char, in_last);
        end
    end

endmodule

`default_nettype wire

### hw/rtl/fsc_queue.sv
// ----------------------------------------------------------------------------
// FEN syntax checker queue
// Short first-in first-out buffer of classified words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsc_queue #(
    parameter int unsigned DEPTH = fsc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire fsc_pkg::fsc_cls_t push_data,
    input  wire logic              pop,
    output fsc_pkg::fsc_cls_t      pop_data,
    output fsc_pkg::fsc_qstat_t    stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    fsc_pkg::fsc_cls_t slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/fsc_back.sv
// ----------------------------------------------------------------------------
// FEN syntax checker back end
// Advance the token checks one word a cycle while the verdict can drain, and register the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsc_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire fsc_pkg::fsc_cls_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   out_verdict
);

    typedef struct packed {
        logic [2:0] tok;
        logic       in_token;
        logic [1:0] len;
        logic [3:0] ranks;
        logic [3:0] squares;
        logic       rank_open;
        logic       dash;
        logic       nonzero;
        logic       err;
    } fsc_state_t;

    fsc_state_t st_reg, st_next;
    logic       out_valid_reg, out_valid_next;
    logic       verdict_reg, verdict_next;
    logic       take;

    function automatic fsc_state_t close_rank(input fsc_state_t s);
        fsc_state_t r;
        r = s;
        if (s.squares != 4'd8) r.err = 1'b1;
        if (s.ranks < 4'd9) r.ranks = s.ranks + 1'b1;
        r.rank_open = 1'b0;
        r.squares   = '0;
        return r;
    endfunction

    function automatic fsc_state_t add_squares(input fsc_state_t s, input logic [3:0] n);
        fsc_state_t r;
        logic [4:0] sum;
        r   = s;
        sum = {1'b0, s.squares} + {1'b0, n};
        r.squares = (sum > 5'd9) ? 4'd9 : sum[3:0];
        return r;
    endfunction

    function automatic fsc_state_t close_token(input fsc_state_t s);
        fsc_state_t r;
        r = s;
        case (s.tok)
            fsc_pkg::TOK_PLACE: begin
                if (r.rank_open) r = close_rank(r);
                if (r.ranks != 4'd8) r.err = 1'b1;
            end
            fsc_pkg::TOK_SIDE: begin
                if (r.len != 2'd1) r.err = 1'b1;
            end
            fsc_pkg::TOK_EP: begin
                if (!r.dash && r.len != 2'd2) r.err = 1'b1;
            end
            fsc_pkg::TOK_FULL: begin
                if (!r.nonzero) r.err = 1'b1;
            end
            default: begin
            end
        endcase
        r.in_token = 1'b0;
        if (r.tok != fsc_pkg::TOK_MAX) r.tok = r.tok + 1'b1;
        return r;
    endfunction

    function automatic fsc_state_t take_byte(input fsc_state_t s, input fsc_pkg::fsc_cls_t c);
        fsc_state_t r;
        logic [1:0] pos;
        r = s;
        if (!r.in_token) begin
            r.in_token = 1'b1;
            r.len      = '0;
            r.dash     = 1'b0;
            r.nonzero  = 1'b0;
            if (r.tok >= fsc_pkg::TOK_DONE) r.err = 1'b1;
        end
        pos = r.len;
        if (r.len != 2'd3) r.len = r.len + 1'b1;
        case (r.tok)
            fsc_pkg::TOK_PLACE: begin
                if (!r.rank_open) begin
                    r.rank_open = 1'b1;
                    r.squares   = '0;
                end
                if (c.slash) begin
                    r = close_rank(r);
                end else if (c.digit) begin
                    if (c.dval == 4'd0 || c.dval == 4'd9) r.err = 1'b1;
                    else r = add_squares(r, c.dval);
                end else if (c.piece) begin
                    r = add_squares(r, 4'd1);
                end else begin
                    r.err = 1'b1;
                end
            end
            fsc_pkg::TOK_SIDE: begin
                if (pos != 2'd0 || !c.side) r.err = 1'b1;
            end
            fsc_pkg::TOK_CASTLE: begin
                if (pos == 2'd0 && c.dash) r.dash = 1'b1;
                else if (r.dash || !c.castle) r.err = 1'b1;
            end
            fsc_pkg::TOK_EP: begin
                if (pos == 2'd0) begin
                    if (c.dash) r.dash = 1'b1;
                    else if (!c.file) r.err = 1'b1;
                end else if (pos == 2'd1) begin
                    if (r.dash || !c.ep_rank) r.err = 1'b1;
                end else begin
                    r.err = 1'b1;
                end
            end
            fsc_pkg::TOK_HALF: begin
                if (!c.digit) r.err = 1'b1;
            end
            fsc_pkg::TOK_FULL: begin
                if (!c.digit) r.err = 1'b1;
                else if (c.dval != 4'd0) r.nonzero = 1'b1;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    assign in_ready    = !out_valid_reg || out_ready;
    assign take        = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign out_verdict = verdict_reg;

    always_comb begin
        fsc_state_t s;
        s              = st_reg;
        out_valid_next = out_valid_reg && !out_ready;
        verdict_next   = verdict_reg;
        if (in_data.blank) begin
            if (s.in_token) s = close_token(s);
        end else begin
            s = take_byte(s, in_data);
        end
        if (in_data.last) begin
            if (s.in_token) s = close_token(s);
            verdict_next   = !s.err && (s.tok == fsc_pkg::TOK_DONE);
            out_valid_next = 1'b1;
            s              = '0;
        end
        st_next = s;
        if (!take) begin
            st_next        = st_reg;
            verdict_next   = verdict_reg;
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        verdict_reg <= verdict_next;
    end

endmodule

`default_nettype wire

### hw/rtl/fen_syntax_checker_unit.sv
// ----------------------------------------------------------------------------
// FEN syntax checker unit
// Streaming syntax check of a chess position string, one verdict per string.
// ----------------------------------------------------------------------------
//   channel   direction   tdata fields (low bit up)        tlast
//   s_axis    in          char_code[7:0]                   last_byte
//   m_axis    out         is_valid[0], zeros [7:1]         -
//
// Rate: one word a cycle sustained while m_axis_tready drains the output
// register. A word passes a classify register, the queue and the checker
// state, and the verdict of a string is held in the output register.
// Reset: aresetn clears all control state; there is no clearing
// pass. Stalls: the output register holds the verdict while m_axis_tready is
// low; the queue lets the front keep taking bytes until it fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "fen_syntax_checker_unit_macros.svh"

module fen_syntax_checker_unit #(
    parameter int unsigned QUEUE_DEPTH = fsc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] char_code
    input  wire logic       s_axis_tlast,   // last_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata    // [0] is_valid, [7:1] zero
);

    // Front to queue
    logic                push;
    fsc_pkg::fsc_cls_t   push_data;
    fsc_pkg::fsc_qstat_t q_stat;

    // Queue to back
    fsc_pkg::fsc_cls_t   pop_data;
    logic                back_ready;
    logic                pop;
    logic                verdict;

    // Classify each byte and hold it until the queue has room
    fsc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_char   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    // Decouple classify from check
    fsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    // Pop a word whenever the checker can take it
    assign pop = !q_stat.empty && back_ready;

    // Token checks and the verdict register
    fsc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (!q_stat.empty),
        .in_ready    (back_ready),
        .in_data     (pop_data),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_verdict (verdict)
    );

    // Pad the one-bit verdict to a whole byte
    assign m_axis_tdata = {7'b0, verdict};

    // A full and empty queue at once means a broken count
    `FSC_ASSERT_NOW(a_queue_state, aclk, aresetn, q_stat.full, !q_stat.empty)
    // A popped last word always leaves a verdict waiting
    `FSC_ASSERT_NEXT(a_verdict_out, aclk, aresetn, pop && pop_data.last, m_axis_tvalid)
    // The front never pushes a held word while the queue is full
    `FSC_ASSERT_NOW(a_front_hold, aclk, aresetn, q_stat.full, !push)

endmodule

`default_nettype wire
